@@ rtl/core/rejected_id_set_table_top_defines.svh @@
// ----------------------------------------------------------------------------
// rejected id set table assertion macros
// shared macros for the port checker of the id set table
// ----------------------------------------------------------------------------
`ifndef REJECTED_ID_SET_TABLE_TOP_DEFINES_SVH
`define REJECTED_ID_SET_TABLE_TOP_DEFINES_SVH

// property checked only out of reset
`define RIST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that also holds while reset is applied
`define RIST_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/rist_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rist_pkg
// sizes, opcodes and sequencer states of the id set table
// ----------------------------------------------------------------------------
package rist_pkg;

    localparam int ENTRIES   = 1024;
    localparam int ID_BITS   = 31;
    localparam int ADDR_BITS = $clog2(ENTRIES);
    localparam int CNT_BITS  = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_RDCLR  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

endpackage

@@ rtl/core/rejected_id_set_table_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rejected_id_set_table_top
// set of nonzero transaction ids with lookup, insert, remove and flag read
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over every slot with busy high
// before the first command. A command is taken when start is high and busy is
// low; every command scans the whole slot memory through its single read
// port, one slot per cycle, and the result appears with done high for one
// cycle in the same cycle that busy falls. A new command may be started in
// that same cycle. Results are not held off: the receiver must take each
// beat when done is high; the result ports hold their value until the next.
module rejected_id_set_table_top
    import rist_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          opcode,
    input  logic [ID_BITS-1:0]  id,
    output logic                done,
    output logic                found,
    output logic                status,
    output logic [CNT_BITS-1:0] entry_count,
    output logic                new_entry_flag
);

    state_t state_reg, state_next;

    logic [ADDR_BITS-1:0] rd_addr_reg, rd_addr_next;
    logic [ADDR_BITS-1:0] rd_idx_reg, rd_idx_next;
    logic                 rd_vld_reg, rd_vld_next;
    logic [ADDR_BITS-1:0] empty_idx_reg, empty_idx_next;
    logic                 empty_seen_reg, empty_seen_next;
    logic                 hit_reg, hit_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic                 flag_reg, flag_next;
    logic                 done_reg, done_next;
    opcode_t              op_reg, op_next;
    logic [ID_BITS-1:0]   id_reg, id_next;

    logic                 found_out_reg, found_out_next;
    logic                 status_out_reg, status_out_next;
    logic [CNT_BITS-1:0]  count_out_reg, count_out_next;
    logic                 flag_out_reg, flag_out_next;

    logic                 ram_we;
    logic [ADDR_BITS-1:0] ram_waddr;
    logic [ID_BITS-1:0]   ram_wdata;
    logic [ID_BITS-1:0]   ram_rdata;

    logic                 addr_last;
    logic                 slot_match;
    logic                 absent_new;
    logic                 ins_ok;
    logic [CNT_BITS-1:0]  cnt_after;
    logic                 flag_after;

    rist_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (ENTRIES)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    assign addr_last  = (rd_addr_reg == ADDR_BITS'(ENTRIES - 1));
    assign slot_match = rd_vld_reg && (ram_rdata == id_reg) && (id_reg != '0);
    assign absent_new = (op_reg == OP_INSERT) && (id_reg != '0) && !hit_reg;
    assign ins_ok     = absent_new && empty_seen_reg;
    assign cnt_after  = (ins_ok && (count_reg < CNT_BITS'(ENTRIES))) ?
                        count_reg + CNT_BITS'(1) : count_reg;
    assign flag_after = flag_reg | ins_ok;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (addr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (addr_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rd_addr_next    = rd_addr_reg;
        rd_idx_next     = rd_addr_reg;
        rd_vld_next     = 1'b0;
        empty_idx_next  = empty_idx_reg;
        empty_seen_next = empty_seen_reg;
        hit_next        = hit_reg;
        count_next      = count_reg;
        flag_next       = flag_reg;
        done_next       = 1'b0;
        op_next         = op_reg;
        id_next         = id_reg;
        found_out_next  = found_out_reg;
        status_out_next = status_out_reg;
        count_out_next  = count_out_reg;
        flag_out_next   = flag_out_reg;
        ram_we          = 1'b0;
        ram_waddr       = rd_addr_reg;
        ram_wdata       = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                rd_addr_next = addr_last ? '0 : rd_addr_reg + ADDR_BITS'(1);
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next         = opcode_t'(opcode);
                    id_next         = id;
                    hit_next        = 1'b0;
                    empty_seen_next = 1'b0;
                    rd_addr_next    = '0;
                end
            end
            ST_SCAN:
            begin
                rd_vld_next  = 1'b1;
                rd_addr_next = addr_last ? '0 : rd_addr_reg + ADDR_BITS'(1);
            end
            ST_DRAIN:
            begin
                rd_vld_next = 1'b0;
            end
            ST_FINISH:
            begin
                // new id goes to the lowest empty slot seen during the scan
                if (ins_ok)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = empty_idx_reg;
                    ram_wdata = id_reg;
                end
                count_next      = cnt_after;
                flag_next       = (op_reg == OP_RDCLR) ? 1'b0 : flag_after;
                done_next       = 1'b1;
                found_out_next  = hit_reg;
                status_out_next = absent_new && !empty_seen_reg;
                count_out_next  = cnt_after;
                flag_out_next   = flag_after;
            end
            default:
            begin
                rd_vld_next = 1'b0;
            end
        endcase

        // slot data from the read issued in the previous cycle
        if (rd_vld_reg)
        begin
            if (slot_match)
            begin
                hit_next = 1'b1;
                if (op_reg == OP_REMOVE)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = rd_idx_reg;
                    ram_wdata = '0;
                    if (count_next != '0)
                    begin
                        count_next = count_reg - CNT_BITS'(1);
                    end
                end
            end
            if ((ram_rdata == '0) && !empty_seen_reg)
            begin
                empty_seen_next = 1'b1;
                empty_idx_next  = rd_idx_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            rd_addr_reg    <= '0;
            rd_vld_reg     <= 1'b0;
            empty_seen_reg <= 1'b0;
            hit_reg        <= 1'b0;
            count_reg      <= '0;
            flag_reg       <= 1'b0;
            done_reg       <= 1'b0;
            op_reg         <= OP_LOOKUP;
        end
        else
        begin
            state_reg      <= state_next;
            rd_addr_reg    <= rd_addr_next;
            rd_vld_reg     <= rd_vld_next;
            empty_seen_reg <= empty_seen_next;
            hit_reg        <= hit_next;
            count_reg      <= count_next;
            flag_reg       <= flag_next;
            done_reg       <= done_next;
            op_reg         <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        empty_idx_reg  <= empty_idx_next;
        id_reg         <= id_next;
        found_out_reg  <= found_out_next;
        status_out_reg <= status_out_next;
        count_out_reg  <= count_out_next;
        flag_out_reg   <= flag_out_next;
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign found          = found_out_reg;
    assign status         = status_out_reg;
    assign entry_count    = count_out_reg;
    assign new_entry_flag = flag_out_reg;

endmodule

@@ rtl/core/rist_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rist_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module rist_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/rist_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rist_checker
// port-level checks of the id set table, bound to the top level
// ----------------------------------------------------------------------------
`include "rejected_id_set_table_top_defines.svh"

module rist_checker
    import rist_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic                done,
    input  logic                found,
    input  logic                status,
    input  logic [CNT_BITS-1:0] entry_count
);

    `RIST_ASSERT_ALWAYS(a_done_idle, done |-> !busy, "result beat while busy")
    `RIST_ASSERT(a_start_busy, (start && !busy) |=> busy, "command taken but busy stays low")
    `RIST_ASSERT(a_done_single, done |=> !done, "two result beats back to back")
    `RIST_ASSERT(a_full_absent, (done && status) |-> !found, "full status on a present id")
    `RIST_ASSERT(a_count_bound, done |-> (entry_count <= CNT_BITS'(ENTRIES)), "count past capacity")

endmodule

bind rejected_id_set_table_top rist_checker u_rist_checker (.*);

@@ sim/rejected_id_set_table_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rejected_id_set_table_checker
// watches the command and result beats of the id set table, keeps its own
// copy of the slot store and compares every result against it
// ----------------------------------------------------------------------------
module rejected_id_set_table_checker
    import rist_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [1:0]          opcode,
    input  logic [ID_BITS-1:0]  id,
    input  logic                done,
    input  logic                found,
    input  logic                status,
    input  logic [CNT_BITS-1:0] entry_count,
    input  logic                new_entry_flag,
    output int                  fail_count,
    output int                  pending
);

    typedef struct {
        opcode_t               op;
        logic [ID_BITS-1:0]    key;
        logic                  found;
        logic                  status;
        logic [CNT_BITS-1:0]   count;
        logic                  flag;
    } answer_t;

    answer_t            answers_due[$];
    logic [ID_BITS-1:0] slot_ids [ENTRIES];
    int unsigned        held_count;
    logic               added_flag;

    // applies one command to the shadow store and returns what the block must answer
    function automatic answer_t apply_command(opcode_t op, logic [ID_BITS-1:0] key);
        answer_t a;
        int      slot;
        a.op     = op;
        a.key    = key;
        a.found  = 1'b0;
        a.status = 1'b0;
        slot     = -1;
        if (key != '0)
        begin
            foreach (slot_ids[i])
            begin
                if (slot_ids[i] == key)
                    a.found = 1'b1;
            end
        end
        if (op == OP_INSERT && key != '0 && !a.found)
        begin
            for (int i = 0; i < ENTRIES && slot < 0; i++)
            begin
                if (slot_ids[i] == '0)
                    slot = i;
            end
            if (slot < 0)
                a.status = 1'b1;
            else
            begin
                slot_ids[slot] = key;
                added_flag     = 1'b1;
                if (held_count < ENTRIES)
                    held_count++;
            end
        end
        else if (op == OP_REMOVE && key != '0)
        begin
            foreach (slot_ids[i])
            begin
                if (slot_ids[i] == key)
                begin
                    slot_ids[i] = '0;
                    if (held_count > 0)
                        held_count--;
                end
            end
        end
        a.flag  = added_flag;
        a.count = CNT_BITS'(held_count);
        // flag is reported before the clear
        if (op == OP_RDCLR)
            added_flag = 1'b0;
        return a;
    endfunction

    task automatic note_fail(string what);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t ns: %s", $time, what);
    endtask

    task automatic check_field(string field, int want, int got, answer_t e);
        if (want != got)
            note_fail($sformatf("%s mismatch on %s id=%h: expected %0d, got %0d",
                                field, e.op.name(), e.key, want, got));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        answer_t e;
        if (!rst_n)
        begin
            foreach (slot_ids[i])
                slot_ids[i] = '0;
            held_count = 0;
            added_flag = 1'b0;
            answers_due.delete();
            pending = 0;
        end
        else
        begin
            // the result beat belongs to an older command, so take it first
            if (done)
            begin
                if (answers_due.size() == 0)
                    note_fail("result beat with no command outstanding");
                else
                begin
                    e = answers_due.pop_front();
                    if ($isunknown({found, status, entry_count, new_entry_flag}))
                        note_fail($sformatf("unknown bits in result of %s id=%h",
                                            e.op.name(), e.key));
                    check_field("found", e.found, found, e);
                    check_field("status", e.status, status, e);
                    check_field("entry_count", e.count, entry_count, e);
                    check_field("new_entry_flag", e.flag, new_entry_flag, e);
                end
            end
            if (start && !busy)
                answers_due.push_back(apply_command(opcode_t'(opcode), id));
            pending = answers_due.size();
        end
    end

endmodule

@@ sim/rejected_id_set_table_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rejected_id_set_table_top_test
// drives lookup, insert, remove and flag commands into the id set table with
// random gaps and reports the checker verdict
// ----------------------------------------------------------------------------
module rejected_id_set_table_top_test;
    import rist_pkg::*;

    localparam int LIMIT        = 10_000_000;
    localparam int POOL_SIZE    = 40;
    localparam int RANDOM_BEATS = 540;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [1:0]          opcode = OP_LOOKUP;
    logic [ID_BITS-1:0]  id = '0;
    logic                busy;
    logic                done;
    logic                found;
    logic                status;
    logic [CNT_BITS-1:0] entry_count;
    logic                new_entry_flag;
    int                  fail_count;
    int                  pending;
    int                  cycles = 0;
    logic [ID_BITS-1:0]  id_pool [POOL_SIZE];

    rejected_id_set_table_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .id             (id),
        .done           (done),
        .found          (found),
        .status         (status),
        .entry_count    (entry_count),
        .new_entry_flag (new_entry_flag)
    );

    rejected_id_set_table_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .id             (id),
        .done           (done),
        .found          (found),
        .status         (status),
        .entry_count    (entry_count),
        .new_entry_flag (new_entry_flag),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // mostly back to back or short, now and then long enough to idle the block
    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 80)
            return $urandom_range(1, 8);
        if (r < 95)
            return $urandom_range(9, ENTRIES + 80);
        return $urandom_range(ENTRIES + 81, 3000);
    endfunction

    function automatic logic [ID_BITS-1:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 15)
            return ID_BITS'($urandom);
        return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function automatic opcode_t pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return OP_LOOKUP;
        if (r < 60)
            return OP_INSERT;
        if (r < 85)
            return OP_REMOVE;
        return OP_RDCLR;
    endfunction

    // called at a falling edge; returns at a falling edge after the beat is taken
    task automatic issue(opcode_t op, logic [ID_BITS-1:0] key, bit hurried);
        int gap;
        start  <= 1'b1;
        opcode <= op;
        id     <= key;
        do @(posedge clk); while (busy);
        @(negedge clk);
        gap = hurried ? $urandom_range(0, 2) : next_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            // junk on the command fields while start is low
            repeat (gap)
            begin
                opcode <= 2'($urandom);
                id     <= ID_BITS'($urandom);
                @(negedge clk);
            end
        end
    endtask

    initial
    begin
        logic [18:0]        fill_tag;
        logic [ID_BITS-1:0] absent_a;
        logic [ID_BITS-1:0] absent_b;
        foreach (id_pool[i])
            id_pool[i] = ID_BITS'($urandom_range(1, 32'h7FFF_FFFF));
        id_pool[0] = 31'h0000_0001;
        id_pool[1] = 31'h7FFF_FFFF;
        id_pool[2] = 31'h4000_0000;
        id_pool[3] = 31'h2AAA_AAAA;
        id_pool[4] = 31'h5555_5555;
        fill_tag   = 19'($urandom);

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // directed corners on an empty and a small table
        issue(OP_RDCLR,  '0,            1'b0);
        issue(OP_LOOKUP, '0,            1'b0);
        issue(OP_INSERT, '0,            1'b0);
        issue(OP_REMOVE, '0,            1'b0);
        issue(OP_INSERT, 31'h0000_0001, 1'b0);
        issue(OP_INSERT, 31'h7FFF_FFFF, 1'b0);
        issue(OP_INSERT, 31'h0000_0001, 1'b0);
        issue(OP_LOOKUP, 31'h0000_0001, 1'b0);
        issue(OP_LOOKUP, 31'h7FFF_FFFF, 1'b0);
        issue(OP_LOOKUP, 31'h0000_0002, 1'b0);
        issue(OP_RDCLR,  31'h7FFF_FFFF, 1'b0);
        issue(OP_RDCLR,  '0,            1'b0);
        issue(OP_INSERT, 31'h7FFF_FFFF, 1'b0);
        issue(OP_REMOVE, 31'h0000_0005, 1'b0);
        issue(OP_REMOVE, 31'h0000_0001, 1'b0);
        issue(OP_LOOKUP, 31'h0000_0001, 1'b0);
        issue(OP_INSERT, 31'h4000_0000, 1'b0);
        issue(OP_REMOVE, 31'h7FFF_FFFF, 1'b0);
        issue(OP_REMOVE, 31'h4000_0000, 1'b0);
        issue(OP_RDCLR,  31'h2AAA_AAAA, 1'b0);
        issue(OP_INSERT, 31'h2AAA_AAAA, 1'b0);
        issue(OP_INSERT, 31'h5555_5555, 1'b0);

        repeat (RANDOM_BEATS)
            issue(pick_op(), pick_id(), 1'b0);

        absent_a = {1'b0, fill_tag, 11'h7FF};
        absent_b = {1'b0, ~fill_tag, 11'h123};
        issue(OP_INSERT, absent_a,                    1'b0);
        issue(OP_INSERT, '0,                          1'b0);
        issue(OP_LOOKUP, {1'b1, fill_tag, 11'd5},     1'b0);
        issue(OP_INSERT, {1'b1, fill_tag, 11'd5},     1'b0);
        issue(OP_RDCLR,  '0,                          1'b0);
        issue(OP_REMOVE, {1'b1, fill_tag, 11'd5},     1'b0);
        issue(OP_INSERT, absent_a,                    1'b0);
        issue(OP_INSERT, absent_b,                    1'b0);
        issue(OP_LOOKUP, absent_a,                    1'b0);
        issue(OP_RDCLR,  absent_b,                    1'b0);
        issue(OP_LOOKUP, '0,                          1'b0);

        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (2 * ENTRIES) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
